// ----- src/proportional_font_glyph_renderer_assert.svh -----
// Assertion macros shared by the renderer checker.
// No dependencies; included by bare file name.
`ifndef PROPORTIONAL_FONT_GLYPH_RENDERER_ASSERT_SVH
`define PROPORTIONAL_FONT_GLYPH_RENDERER_ASSERT_SVH
// checked while out of reset
`define PFGR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfgr assertion failed");
// checked at every edge, reset included
`define PFGR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pfgr assertion failed");
`endif

// ----- src/pfgr_pkg.sv -----
// Shared types and constants of the proportional glyph renderer.
// No dependencies.
`default_nettype none
package pfgr_pkg;
  localparam int OFFSET_ENTRIES_DEF  = 257;
  localparam int BITMAP_BYTES_DEF    = 4096;
  localparam int MAX_GLYPH_WIDTH_DEF = 32;
  localparam int MAX_GLYPH_ROWS_DEF  = 32;
  localparam int MASK_BITS           = 32;
  localparam int BIT_ADDR_W          = 20;

  typedef enum logic [1:0] {
    OP_WR_OFFSET = 2'd0,
    OP_WR_BITMAP = 2'd1,
    OP_SET_PEN   = 2'd2,
    OP_DRAW      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_RIGHT  = 3'd1,
    REG_CLIP_TOP    = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_FIRST_CODE  = 3'd4,
    REG_END_CODE    = 3'd5,
    REG_GLYPH_ROWS  = 3'd6,
    REG_ROW_STRIDE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic accept;      // input word taken this cycle
    logic rd_hi;       // read offset entry ci+1 instead of ci
    logic latch_off0;
    logic start_glyph;
    logic fetch;
    logic load_out;
    logic next_row;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic code_ok;
    logic width_ok;
    logic rows_zero;
    logic fetch_done;
    logic last_row;
  } sts_t;
endpackage
`default_nettype wire

// ----- src/pfgr_if.sv -----
// Valid/ready channel interfaces: command words in, row words out.
// Depends on nothing.
`default_nettype none
interface pfgr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] table_index;
  logic [15:0] write_value;
  logic [7:0]  char_code;
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic [15:0] color;
  modport source (output valid, op, table_index, write_value, char_code, pen_x, pen_y,
                  color, input ready);
  modport sink (input valid, op, table_index, write_value, char_code, pen_x, pen_y,
                color, output ready);
endinterface

interface pfgr_row_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] row_x;
  logic signed [15:0] row_y;
  logic [31:0] pixel_mask;
  logic [15:0] pixel_color;
  logic        last_row;
  modport source (output valid, row_x, row_y, pixel_mask, pixel_color, last_row,
                  input ready);
  modport sink (input valid, row_x, row_y, pixel_mask, pixel_color, last_row,
                output ready);
endinterface
`default_nettype wire

// ----- src/proportional_font_glyph_renderer.sv -----
// Top level of the proportional 1bpp glyph renderer: controller + datapath.
// Depends on pfgr_pkg, pfgr_if, pfgr_controller, pfgr_datapath.
//
// cmd channel takes one word per op: offset-table write, bitmap byte write,
// pen/color set, or draw-character. cmd.ready is high only while idle.
// Writes and pen sets complete when accepted. After a draw is accepted, the
// offset lookup runs through S_RD0, S_RD1 and S_CHK (one offset-table read
// port, two reads, width check), then per glyph row S_FETCH fetches NB
// bitmap bytes (NB = ceil(min(MAX_GLYPH_WIDTH,32)/8)+1, 5 at the defaults,
// one bitmap read port) and S_ROW loads the row word. Each row word on the
// row channel carries the clipped pixel mask; the final row of a character
// has last_row set. The output register lets the next row's fetch or the
// next command proceed while a row word waits; if the receiver stalls, the
// block holds at the next row load until the register frees. Reset
// initialises config registers and clears pen and color; the offset table
// and bitmap are not cleared and must be written before use.
// Config writes (cfg_we/cfg_index/cfg_data) must be made only while idle.
`default_nettype none
module proportional_font_glyph_renderer
  import pfgr_pkg::*;
#(
  parameter int OFFSET_ENTRIES  = OFFSET_ENTRIES_DEF,
  parameter int BITMAP_BYTES    = BITMAP_BYTES_DEF,
  parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_GLYPH_ROWS  = MAX_GLYPH_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  pfgr_cmd_if.sink         cmd,
  pfgr_row_if.source       row
);
  cmd_t cmd_bus;
  sts_t sts_bus;

  pfgr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_op     (cmd.op),
    .in_ready  (cmd.ready),
    .out_valid (row.valid),
    .out_ready (row.ready),
    .sts       (sts_bus),
    .cmd       (cmd_bus)
  );

  pfgr_datapath #(
    .OFFSET_ENTRIES  (OFFSET_ENTRIES),
    .BITMAP_BYTES    (BITMAP_BYTES),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (cmd.op),
    .table_index (cmd.table_index),
    .write_value (cmd.write_value),
    .char_code   (cmd.char_code),
    .pen_x       (cmd.pen_x),
    .pen_y       (cmd.pen_y),
    .color       (cmd.color),
    .cmd         (cmd_bus),
    .sts         (sts_bus),
    .row_x       (row.row_x),
    .row_y       (row.row_y),
    .pixel_mask  (row.pixel_mask),
    .pixel_color (row.pixel_color),
    .last_row    (row.last_row)
  );
endmodule
`default_nettype wire

// ----- src/pfgr_datapath.sv -----
// Datapath: config registers, pen state, offset table and bitmap memories,
// byte window fetch and clipped mask build. Depends on pfgr_pkg.
`default_nettype none
module pfgr_datapath
  import pfgr_pkg::*;
#(
  parameter int OFFSET_ENTRIES  = OFFSET_ENTRIES_DEF,
  parameter int BITMAP_BYTES    = BITMAP_BYTES_DEF,
  parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_GLYPH_ROWS  = MAX_GLYPH_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  op,
  input  wire logic [11:0] table_index,
  input  wire logic [15:0] write_value,
  input  wire logic [7:0]  char_code,
  input  wire logic [15:0] pen_x,
  input  wire logic [15:0] pen_y,
  input  wire logic [15:0] color,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic [15:0]      row_x,
  output logic [15:0]      row_y,
  output logic [31:0]      pixel_mask,
  output logic [15:0]      pixel_color,
  output logic             last_row
);
  localparam int LIM = (MAX_GLYPH_WIDTH > MASK_BITS) ? MASK_BITS : MAX_GLYPH_WIDTH;
  localparam int NB  = (LIM + 7) / 8 + 1;
  localparam int WW  = NB * 8;
  localparam int IW  = $clog2(OFFSET_ENTRIES);
  localparam int BW  = $clog2(BITMAP_BYTES);
  localparam int KW  = $clog2(NB + 1);

  logic [15:0] clip_left, clip_right, clip_top, clip_bottom;
  logic [7:0]  first_code;
  logic [8:0]  end_code;
  logic [5:0]  glyph_rows;
  logic [9:0]  row_stride;
  logic [15:0] pen_x_pos, pen_y_pos, draw_color;

  logic [15:0] offs [OFFSET_ENTRIES];
  logic [7:0]  bitmap [BITMAP_BYTES];

  logic [8:0]  ci;
  logic        code_ok;
  logic [15:0] off_q, off0;
  logic [15:0] width_q;
  logic [BIT_ADDR_W-1:0] base_q;
  logic [5:0]  r_q;
  logic [KW-1:0] fk;
  logic [7:0]  bm_q;
  logic        oor_q, pend_q;
  logic [WW-1:0] win;

  // combinational helpers
  logic [8:0]  ci_next, ci_sel;
  logic [5:0]  rows_eff;
  logic [31:0] tix, rd_addr;
  logic        rd_issue;
  logic [15:0] adv_w;
  logic [WW-1:0] shifted;
  logic signed [16:0] px, y, xc, cl, cr, ct, cb;
  logic        y_in;
  logic [31:0] mask;

  assign ci_next  = 9'(char_code) - 9'(first_code);
  assign ci_sel   = cmd.rd_hi ? ci + 9'd1 : ci;
  assign rows_eff = (32'(glyph_rows) > MAX_GLYPH_ROWS) ? 6'(MAX_GLYPH_ROWS) : glyph_rows;
  assign tix      = 32'(table_index);
  assign rd_addr  = 32'(base_q[BIT_ADDR_W-1:3]) + 32'(fk);
  assign rd_issue = cmd.fetch && (32'(fk) < NB);
  // a glyph with no rows advances in the same cycle its width is found
  assign adv_w    = cmd.start_glyph ? off_q - off0 : width_q;

  assign sts.code_ok    = code_ok;
  assign sts.width_ok   = off_q > off0;
  assign sts.rows_zero  = (rows_eff == 6'd0);
  assign sts.fetch_done = (32'(fk) == NB);
  assign sts.last_row   = (r_q + 6'd1 == rows_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= 16'd0;
      clip_right  <= 16'd32767;
      clip_top    <= 16'd0;
      clip_bottom <= 16'd32767;
      first_code  <= 8'd0;
      end_code    <= 9'd0;
      glyph_rows  <= 6'd0;
      row_stride  <= 10'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_LEFT:   clip_left   <= cfg_data;
        REG_CLIP_RIGHT:  clip_right  <= cfg_data;
        REG_CLIP_TOP:    clip_top    <= cfg_data;
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        REG_FIRST_CODE:  first_code  <= cfg_data[7:0];
        REG_END_CODE:    end_code    <= cfg_data[8:0];
        REG_GLYPH_ROWS:  glyph_rows  <= cfg_data[5:0];
        REG_ROW_STRIDE:  row_stride  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x_pos  <= 16'd0;
      pen_y_pos  <= 16'd0;
      draw_color <= 16'd0;
    end else if (cmd.accept && op_t'(op) == OP_SET_PEN) begin
      pen_x_pos  <= pen_x;
      pen_y_pos  <= pen_y;
      draw_color <= color;
    end else if (cmd.advance) begin
      pen_x_pos  <= pen_x_pos + adv_w;
    end
  end

  // offset table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(op) == OP_WR_OFFSET && tix < OFFSET_ENTRIES)
      offs[tix[IW-1:0]] <= write_value;
    off_q <= offs[ci_sel[IW-1:0]];
  end

  // bitmap: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(op) == OP_WR_BITMAP && tix < BITMAP_BYTES)
      bitmap[tix[BW-1:0]] <= write_value[7:0];
    bm_q <= bitmap[rd_addr[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    oor_q <= rd_addr >= BITMAP_BYTES;
    if (cmd.accept) begin
      ci      <= ci_next;
      code_ok <= (char_code >= first_code) && (9'(char_code) < end_code) &&
                 (32'(ci_next) + 32'd1 < OFFSET_ENTRIES);
    end
    if (cmd.latch_off0) off0 <= off_q;
    if (cmd.start_glyph) begin
      width_q <= off_q - off0;
      base_q  <= BIT_ADDR_W'(off0);
      r_q     <= 6'd0;
      fk      <= '0;
    end else if (cmd.next_row) begin
      base_q  <= base_q + BIT_ADDR_W'({row_stride, 3'b000});
      r_q     <= r_q + 6'd1;
      fk      <= '0;
    end else if (rd_issue) begin
      fk      <= fk + KW'(1);
    end
    if (pend_q) win <= {win[WW-9:0], oor_q ? 8'd0 : bm_q};
  end

  always_comb begin
    shifted = win << base_q[2:0];
    px = $signed({pen_x_pos[15], pen_x_pos});
    cl = $signed({clip_left[15], clip_left});
    cr = $signed({clip_right[15], clip_right});
    ct = $signed({clip_top[15], clip_top});
    cb = $signed({clip_bottom[15], clip_bottom});
    y  = $signed({pen_y_pos[15], pen_y_pos}) + $signed({11'd0, r_q});
    y_in = (y >= ct) && (y <= cb);
    mask = '0;
    xc = '0;
    for (int c = 0; c < LIM; c++) begin
      xc = px + 17'(c);
      mask[c] = y_in && shifted[WW-1-c] && (16'(c) < width_q) && (xc >= cl) && (xc <= cr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      row_x       <= pen_x_pos;
      row_y       <= pen_y_pos + 16'(r_q);
      pixel_mask  <= mask;
      pixel_color <= draw_color;
      last_row    <= sts.last_row;
    end
  end
endmodule
`default_nettype wire

// ----- src/pfgr_controller.sv -----
// Controller: sequences offset lookup, per-row byte fetch and row output.
// Depends on pfgr_pkg.
`default_nettype none
module pfgr_controller
  import pfgr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_RD1, S_CHK, S_FETCH, S_ROW
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // S_RD0 reads entry ci, S_RD1 latches it and reads entry ci+1
  always_comb begin
    cmd = '0;
    cmd.accept = in_valid && in_ready;
    unique case (state)
      S_IDLE:  ;
      S_RD0:   ;
      S_RD1: begin
        cmd.rd_hi      = 1'b1;
        cmd.latch_off0 = 1'b1;
      end
      S_CHK: begin
        cmd.start_glyph = sts.width_ok;
        cmd.advance     = sts.width_ok && sts.rows_zero;
      end
      S_FETCH: cmd.fetch = 1'b1;
      S_ROW: begin
        cmd.load_out = slot_free;
        cmd.next_row = slot_free && !sts.last_row;
        cmd.advance  = slot_free && sts.last_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (cmd.accept && op_t'(in_op) == OP_DRAW) state <= S_RD0;
        S_RD0:   state <= sts.code_ok ? S_RD1 : S_IDLE;
        S_RD1:   state <= S_CHK;
        S_CHK:   state <= (sts.width_ok && !sts.rows_zero) ? S_FETCH : S_IDLE;
        S_FETCH: if (sts.fetch_done) state <= S_ROW;
        S_ROW: begin
          if (slot_free) state <= sts.last_row ? S_IDLE : S_FETCH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/pfgr_checker.sv -----
// Port-level checker for the glyph renderer, bound to the top level.
// Depends on pfgr_pkg and proportional_font_glyph_renderer_assert.svh.
`default_nettype none
`include "proportional_font_glyph_renderer_assert.svh"
module pfgr_checker
  import pfgr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_op,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_mask,
  input wire logic        out_last
);
  // a pending row word stays up until taken
  `PFGR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  // a stalled row word keeps its mask
  `PFGR_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_mask) && $stable(out_last))
  // reset empties the output register
  `PFGR_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)
  // a non-draw word with nothing pending never yields a row word
  `PFGR_ASSERT(a_nodraw_quiet, clk, rst, in_valid && in_ready && (in_op != OP_DRAW) && !out_valid |=> !out_valid)
endmodule

bind proportional_font_glyph_renderer pfgr_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .in_op     (cmd.op),
  .out_valid (row.valid),
  .out_ready (row.ready),
  .out_mask  (row.pixel_mask),
  .out_last  (row.last_row)
);
`default_nettype wire
